// ----- rtl/core/bst_pkg.sv -----
package bst_pkg;

   localparam int OFFSET_BITS = 16;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int RSP_DATA_BITS = 40;

   localparam logic [4:0] KIND_EOF     = 5'd0;
   localparam logic [4:0] KIND_IDENT   = 5'd1;
   localparam logic [4:0] KIND_NUMBER  = 5'd2;
   localparam logic [4:0] KIND_STRING  = 5'd3;
   localparam logic [4:0] KIND_PRINT   = 5'd4;
   localparam logic [4:0] KIND_IF      = 5'd5;
   localparam logic [4:0] KIND_ELSE    = 5'd6;
   localparam logic [4:0] KIND_WHILE   = 5'd7;
   localparam logic [4:0] KIND_EQEQ    = 5'd8;
   localparam logic [4:0] KIND_ASSIGN  = 5'd9;
   localparam logic [4:0] KIND_LE      = 5'd10;
   localparam logic [4:0] KIND_PERCENT = 5'd11;
   localparam logic [4:0] KIND_PLUS    = 5'd12;
   localparam logic [4:0] KIND_MINUS   = 5'd13;
   localparam logic [4:0] KIND_STAR    = 5'd14;
   localparam logic [4:0] KIND_SLASH   = 5'd15;
   localparam logic [4:0] KIND_SEMI    = 5'd16;
   localparam logic [4:0] KIND_LPAREN  = 5'd17;
   localparam logic [4:0] KIND_RPAREN  = 5'd18;
   localparam logic [4:0] KIND_LBRACE  = 5'd19;
   localparam logic [4:0] KIND_RBRACE  = 5'd20;
   localparam logic [4:0] KIND_UNKNOWN = 5'd21;

   // keyword text, first character in the low byte
   localparam logic [39:0] WORD_PRINT = 40'h746E697270;
   localparam logic [39:0] WORD_IF    = 40'h0000006669;
   localparam logic [39:0] WORD_ELSE  = 40'h0065736C65;
   localparam logic [39:0] WORD_WHILE = 40'h656C696877;

   typedef logic [OFFSET_BITS-1:0] offset_type;

   typedef struct packed {
      logic [4:0]  kind;
      logic [15:0] start;
      logic [15:0] length;
   } token_type;

   // one or two tokens caused by the same input byte
   typedef struct packed {
      logic      two;
      token_type tok0;
      token_type tok1;
   } entry_type;

   function automatic logic [15:0] clip16(offset_type v);
      logic [OFFSET_BITS+15:0] wide;
      wide = {16'd0, v};
      if (wide > (OFFSET_BITS+16)'(16'hFFFF)) begin
         return 16'hFFFF;
      end
      return wide[15:0];
   endfunction

   function automatic offset_type sat_inc(offset_type v);
      if (v == '1) begin
         return v;
      end
      return v + offset_type'(1);
   endfunction

   function automatic token_type make_token(logic [4:0] kind, offset_type start,
                                            offset_type length);
      token_type t;
      t.kind   = kind;
      t.start  = clip16(start);
      t.length = clip16(length);
      return t;
   endfunction

endpackage

// ----- rtl/core/byte_stream_tokenizer.sv -----
// Streaming lexer: source text enters one byte per transaction on req_ (byte 0 ends
// the text) and tokens leave on rsp_ as kind, start offset and length, with tlast
// on the final token caused by a byte. The lexer front end takes a byte every
// cycle while the queue has room and turns it into zero, one or two tokens in
// the same cycle; those go into a four-entry queue, and the back end sends one
// token per cycle while rsp_tready is high. Input rate is one byte per cycle as
// long as the queue has room; a byte that yields two tokens sends both on the
// output, so the output port sets the sustained rate when tokens come faster.
module byte_stream_tokenizer (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,  // byte_value
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [bst_pkg::RSP_DATA_BITS-1:0] rsp_tdata,  // token_kind, token_start,
                                                         // token_length, zero pad
   output logic                              rsp_tlast   // last_of_run
);

   logic               accept, push, full, pop, head_valid;
   bst_pkg::entry_type push_entry, head_entry;

   assign req_tready = !full;
   assign accept     = req_tvalid && req_tready;

   bst_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .byte_value (req_tdata),
      .push       (push),
      .push_entry (push_entry)
   );

   bst_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   bst_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ----- rtl/core/bst_front.sv -----
module bst_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [7:0]         byte_value,
   output logic               push,
   output bst_pkg::entry_type push_entry
);

   localparam logic [2:0] MODE_IDLE   = 3'd0;
   localparam logic [2:0] MODE_IDENT  = 3'd1;
   localparam logic [2:0] MODE_NUMBER = 3'd2;
   localparam logic [2:0] MODE_STRING = 3'd3;
   localparam logic [2:0] MODE_EQ     = 3'd4;
   localparam logic [2:0] MODE_LT     = 3'd5;

   logic [2:0]          mode_ff, mode_in;
   bst_pkg::offset_type pos_ff, pos_in;
   bst_pkg::offset_type pstart_ff, pstart_in;
   bst_pkg::offset_type plen_ff, plen_in;
   logic [39:0]         prefix_ff, prefix_in;

   logic is_space, is_digit, is_alpha;

   // what the byte does when no token is pending
   logic                fi_emit;
   logic [4:0]          fi_kind;
   logic [2:0]          fi_mode;
   logic                fi_begin;
   logic                fi_clear_len;

   logic                apply_idle;
   logic [1:0]          count;
   bst_pkg::token_type  tok0, tok1, fi_tok;
   logic [4:0]          id_kind;

   always_comb begin
      is_space = (byte_value == 8'd32) || (byte_value >= 8'd9 && byte_value <= 8'd13);
      is_digit = (byte_value >= "0") && (byte_value <= "9");
      is_alpha = ((byte_value >= "a") && (byte_value <= "z")) ||
                 ((byte_value >= "A") && (byte_value <= "Z"));
   end

   always_comb begin
      fi_emit      = 1'b0;
      fi_kind      = bst_pkg::KIND_UNKNOWN;
      fi_mode      = MODE_IDLE;
      fi_begin     = 1'b0;
      fi_clear_len = 1'b0;
      if (byte_value == 8'd0) begin
         fi_emit = 1'b1;
         fi_kind = bst_pkg::KIND_EOF;
      end else if (is_space) begin
         fi_emit = 1'b0;
      end else if (is_alpha) begin
         fi_mode  = MODE_IDENT;
         fi_begin = 1'b1;
      end else if (is_digit) begin
         fi_mode  = MODE_NUMBER;
         fi_begin = 1'b1;
      end else begin
         case (byte_value)
            "\"": begin
               fi_mode      = MODE_STRING;
               fi_begin     = 1'b1;
               fi_clear_len = 1'b1;
            end
            "=": begin
               fi_mode  = MODE_EQ;
               fi_begin = 1'b1;
            end
            "<": begin
               fi_mode  = MODE_LT;
               fi_begin = 1'b1;
            end
            "%": begin fi_emit = 1'b1; fi_kind = bst_pkg::KIND_PERCENT; end
            "+": begin fi_emit = 1'b1; fi_kind = bst_pkg::KIND_PLUS;    end
            "-": begin fi_emit = 1'b1; fi_kind = bst_pkg::KIND_MINUS;   end
            "*": begin fi_emit = 1'b1; fi_kind = bst_pkg::KIND_STAR;    end
            "/": begin fi_emit = 1'b1; fi_kind = bst_pkg::KIND_SLASH;   end
            ";": begin fi_emit = 1'b1; fi_kind = bst_pkg::KIND_SEMI;    end
            "(": begin fi_emit = 1'b1; fi_kind = bst_pkg::KIND_LPAREN;  end
            ")": begin fi_emit = 1'b1; fi_kind = bst_pkg::KIND_RPAREN;  end
            "{": begin fi_emit = 1'b1; fi_kind = bst_pkg::KIND_LBRACE;  end
            "}": begin fi_emit = 1'b1; fi_kind = bst_pkg::KIND_RBRACE;  end
            default: begin fi_emit = 1'b1; fi_kind = bst_pkg::KIND_UNKNOWN; end
         endcase
      end
      // EOF has length 0, every single-byte token length 1
      fi_tok = bst_pkg::make_token(fi_kind, pos_ff,
                  (byte_value == 8'd0) ? bst_pkg::offset_type'(0)
                                       : bst_pkg::offset_type'(1));
   end

   always_comb begin
      id_kind = bst_pkg::KIND_IDENT;
      if (plen_ff == bst_pkg::offset_type'(5) && prefix_ff == bst_pkg::WORD_PRINT) begin
         id_kind = bst_pkg::KIND_PRINT;
      end else if (plen_ff == bst_pkg::offset_type'(2) && prefix_ff == bst_pkg::WORD_IF) begin
         id_kind = bst_pkg::KIND_IF;
      end else if (plen_ff == bst_pkg::offset_type'(4) &&
                   prefix_ff == bst_pkg::WORD_ELSE) begin
         id_kind = bst_pkg::KIND_ELSE;
      end else if (plen_ff == bst_pkg::offset_type'(5) &&
                   prefix_ff == bst_pkg::WORD_WHILE) begin
         id_kind = bst_pkg::KIND_WHILE;
      end
   end

   always_comb begin
      mode_in    = mode_ff;
      pstart_in  = pstart_ff;
      plen_in    = plen_ff;
      prefix_in  = prefix_ff;
      apply_idle = 1'b0;
      count      = 2'd0;
      tok0       = fi_tok;
      tok1       = fi_tok;

      case (mode_ff)
         MODE_IDENT: begin
            if (is_alpha || is_digit) begin
               if (plen_ff < bst_pkg::offset_type'(5)) begin
                  prefix_in[8*plen_ff[2:0] +: 8] = byte_value;
               end
               plen_in = bst_pkg::sat_inc(plen_ff);
            end else begin
               tok0       = bst_pkg::make_token(id_kind, pstart_ff, plen_ff);
               count      = 2'd1;
               apply_idle = 1'b1;
            end
         end
         MODE_NUMBER: begin
            if (is_digit) begin
               plen_in = bst_pkg::sat_inc(plen_ff);
            end else begin
               tok0       = bst_pkg::make_token(bst_pkg::KIND_NUMBER, pstart_ff, plen_ff);
               count      = 2'd1;
               apply_idle = 1'b1;
            end
         end
         MODE_STRING: begin
            if (byte_value == "\"") begin
               tok0    = bst_pkg::make_token(bst_pkg::KIND_STRING,
                                             bst_pkg::sat_inc(pstart_ff), plen_ff);
               count   = 2'd1;
               mode_in = MODE_IDLE;
            end else if (byte_value == 8'd0) begin
               tok0       = bst_pkg::make_token(bst_pkg::KIND_UNKNOWN, pstart_ff,
                                                bst_pkg::offset_type'(0));
               count      = 2'd1;
               apply_idle = 1'b1;
            end else begin
               plen_in = bst_pkg::sat_inc(plen_ff);
            end
         end
         MODE_EQ, MODE_LT: begin
            if (byte_value == "=") begin
               tok0    = bst_pkg::make_token((mode_ff == MODE_EQ) ? bst_pkg::KIND_EQEQ
                                                                  : bst_pkg::KIND_LE,
                                             pstart_ff, bst_pkg::offset_type'(2));
               count   = 2'd1;
               mode_in = MODE_IDLE;
            end else begin
               tok0       = bst_pkg::make_token((mode_ff == MODE_EQ) ? bst_pkg::KIND_ASSIGN
                                                                     : bst_pkg::KIND_UNKNOWN,
                                                pstart_ff, bst_pkg::offset_type'(1));
               count      = 2'd1;
               apply_idle = 1'b1;
            end
         end
         default: begin
            apply_idle = 1'b1;
         end
      endcase

      if (apply_idle) begin
         mode_in = fi_mode;
         if (fi_begin) begin
            pstart_in = pos_ff;
            if (is_alpha || is_digit) begin
               plen_in = bst_pkg::offset_type'(1);
            end else if (fi_clear_len) begin
               plen_in = bst_pkg::offset_type'(0);
            end
            if (is_alpha) begin
               prefix_in = {32'd0, byte_value};
            end
         end
         if (fi_emit) begin
            // the idle token lands behind any token closed by this byte
            if (count == 2'd0) begin
               tok0 = fi_tok;
            end else begin
               tok1 = fi_tok;
            end
            count = count + 2'd1;
         end
      end

      if (byte_value == 8'd0) begin
         pos_in  = bst_pkg::offset_type'(0);
         mode_in = MODE_IDLE;
      end else begin
         pos_in = bst_pkg::sat_inc(pos_ff);
      end
   end

   always_comb begin
      push            = accept && (count != 2'd0);
      push_entry.two  = (count == 2'd2);
      push_entry.tok0 = tok0;
      push_entry.tok1 = tok1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         pos_ff    <= '0;
         pstart_ff <= '0;
         plen_ff   <= '0;
         prefix_ff <= '0;
      end else if (accept) begin
         mode_ff   <= mode_in;
         pos_ff    <= pos_in;
         pstart_ff <= pstart_in;
         plen_ff   <= plen_in;
         prefix_ff <= prefix_in;
      end
   end

endmodule

// ----- rtl/core/bst_queue.sv -----
module bst_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  bst_pkg::entry_type push_entry,
   output logic               full,
   input  logic               pop,
   output logic               head_valid,
   output bst_pkg::entry_type head_entry
);

   bst_pkg::entry_type mem [bst_pkg::QUEUE_DEPTH];

   logic [bst_pkg::QUEUE_PTR_BITS-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [bst_pkg::QUEUE_PTR_BITS:0]   cnt_ff, cnt_in;

   always_comb begin
      full       = (cnt_ff == (bst_pkg::QUEUE_PTR_BITS+1)'(bst_pkg::QUEUE_DEPTH));
      head_valid = (cnt_ff != '0);
      head_entry = mem[rd_ff];
      wr_in      = push ? wr_ff + 1'b1 : wr_ff;
      rd_in      = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in     = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ----- rtl/core/bst_back.sv -----
module bst_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                head_valid,
   input  bst_pkg::entry_type                  head_entry,
   output logic                                pop,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [bst_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   output logic                                rsp_tlast
);

   logic               valid_ff, valid_in;
   logic               sel_ff, sel_in;
   bst_pkg::entry_type cur_ff, cur_in;
   bst_pkg::token_type tok;
   logic               fire, last;

   always_comb begin
      tok        = sel_ff ? cur_ff.tok1 : cur_ff.tok0;
      last       = sel_ff || !cur_ff.two;
      fire       = valid_ff && rsp_tready;
      pop        = head_valid && (!valid_ff || (fire && last));
      rsp_tvalid = valid_ff;
      rsp_tlast  = last;
      rsp_tdata  = {3'd0, tok.length, tok.start, tok.kind};

      valid_in = valid_ff;
      sel_in   = sel_ff;
      cur_in   = cur_ff;
      if (pop) begin
         valid_in = 1'b1;
         sel_in   = 1'b0;
         cur_in   = head_entry;
      end else if (fire) begin
         if (last) begin
            valid_in = 1'b0;
         end else begin
            sel_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sel_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         sel_ff   <= sel_in;
      end
   end

endmodule

// ----- tb/tb_byte_stream_tokenizer.sv -----
`timescale 1ns / 100ps

module tb_byte_stream_tokenizer;

   localparam int IDLE_LIMIT = 2000;
   localparam int RANDOM_BYTES = 950;

   typedef enum logic [2:0] {
      LEX_IDLE, LEX_IDENT, LEX_NUMBER, LEX_STRING, LEX_EQ, LEX_LT
   } lex_mode_type;

   typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_type;

   typedef struct {
      logic [4:0]  kind;
      logic [15:0] start;
      logic [15:0] length;
      logic        last;
   } token_record_type;

   function automatic bit is_space(logic [7:0] b);
      return b == 8'd32 || (b >= 8'd9 && b <= 8'd13);
   endfunction

   function automatic bit is_digit(logic [7:0] b);
      return b >= "0" && b <= "9";
   endfunction

   function automatic bit is_alpha(logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
   endfunction

   class token_scoreboard_type;
      token_record_type    expected[$];
      lex_mode_type        mode;
      bst_pkg::offset_type pos;
      bst_pkg::offset_type tok_start;
      bst_pkg::offset_type tok_len;
      logic [39:0]         prefix;
      int                  errors;

      function new();
         mode = LEX_IDLE;
         pos = '0;
         tok_start = '0;
         tok_len = '0;
         prefix = '0;
         errors = 0;
      endfunction

      function int pending();
         return expected.size();
      endfunction

      function bst_pkg::offset_type sat_step(bst_pkg::offset_type v);
         return (v == '1) ? v : v + bst_pkg::offset_type'(1);
      endfunction

      function logic [15:0] to16(bst_pkg::offset_type v);
         if ($bits(v) > 16 && 64'(v) > 64'hFFFF) return 16'hFFFF;
         return 16'(v);
      endfunction

      function void add_token(logic [4:0] kind, bst_pkg::offset_type start,
                              bst_pkg::offset_type len);
         token_record_type t;
         t.kind = kind;
         t.start = to16(start);
         t.length = to16(len);
         t.last = 1'b0;
         expected.push_back(t);
      endfunction

      function logic [4:0] word_kind();
         if (tok_len == bst_pkg::offset_type'(5) && prefix == bst_pkg::WORD_PRINT)
            return bst_pkg::KIND_PRINT;
         if (tok_len == bst_pkg::offset_type'(2) && prefix == bst_pkg::WORD_IF)
            return bst_pkg::KIND_IF;
         if (tok_len == bst_pkg::offset_type'(4) && prefix == bst_pkg::WORD_ELSE)
            return bst_pkg::KIND_ELSE;
         if (tok_len == bst_pkg::offset_type'(5) && prefix == bst_pkg::WORD_WHILE)
            return bst_pkg::KIND_WHILE;
         return bst_pkg::KIND_IDENT;
      endfunction

      // byte arriving with nothing pending
      function void from_idle(logic [7:0] b);
         logic [4:0] kind;
         mode = LEX_IDLE;
         if (b == 8'd0) begin
            add_token(bst_pkg::KIND_EOF, pos, '0);
            return;
         end
         if (is_space(b)) return;
         if (is_alpha(b)) begin
            mode = LEX_IDENT;
            tok_start = pos;
            tok_len = bst_pkg::offset_type'(1);
            prefix = 40'(b);
            return;
         end
         if (is_digit(b)) begin
            mode = LEX_NUMBER;
            tok_start = pos;
            tok_len = bst_pkg::offset_type'(1);
            return;
         end
         case (b)
            "\"": begin
               mode = LEX_STRING;
               tok_start = pos;
               tok_len = '0;
               return;
            end
            "=": begin
               mode = LEX_EQ;
               tok_start = pos;
               return;
            end
            "<": begin
               mode = LEX_LT;
               tok_start = pos;
               return;
            end
            "%": kind = bst_pkg::KIND_PERCENT;
            "+": kind = bst_pkg::KIND_PLUS;
            "-": kind = bst_pkg::KIND_MINUS;
            "*": kind = bst_pkg::KIND_STAR;
            "/": kind = bst_pkg::KIND_SLASH;
            ";": kind = bst_pkg::KIND_SEMI;
            "(": kind = bst_pkg::KIND_LPAREN;
            ")": kind = bst_pkg::KIND_RPAREN;
            "{": kind = bst_pkg::KIND_LBRACE;
            "}": kind = bst_pkg::KIND_RBRACE;
            default: kind = bst_pkg::KIND_UNKNOWN;
         endcase
         add_token(kind, pos, bst_pkg::offset_type'(1));
      endfunction

      function void note_byte(logic [7:0] b);
         int first;
         first = expected.size();
         case (mode)
            LEX_IDENT: begin
               if (is_alpha(b) || is_digit(b)) begin
                  if (tok_len < bst_pkg::offset_type'(5)) prefix |= 40'(b) << (8 * tok_len);
                  tok_len = sat_step(tok_len);
               end else begin
                  add_token(word_kind(), tok_start, tok_len);
                  from_idle(b);
               end
            end
            LEX_NUMBER: begin
               if (is_digit(b)) begin
                  tok_len = sat_step(tok_len);
               end else begin
                  add_token(bst_pkg::KIND_NUMBER, tok_start, tok_len);
                  from_idle(b);
               end
            end
            LEX_STRING: begin
               if (b == "\"") begin
                  add_token(bst_pkg::KIND_STRING, sat_step(tok_start), tok_len);
                  mode = LEX_IDLE;
               end else if (b == 8'd0) begin
                  // unterminated string
                  add_token(bst_pkg::KIND_UNKNOWN, tok_start, '0);
                  from_idle(b);
               end else begin
                  tok_len = sat_step(tok_len);
               end
            end
            LEX_EQ: begin
               if (b == "=") begin
                  add_token(bst_pkg::KIND_EQEQ, tok_start, bst_pkg::offset_type'(2));
                  mode = LEX_IDLE;
               end else begin
                  add_token(bst_pkg::KIND_ASSIGN, tok_start, bst_pkg::offset_type'(1));
                  from_idle(b);
               end
            end
            LEX_LT: begin
               if (b == "=") begin
                  add_token(bst_pkg::KIND_LE, tok_start, bst_pkg::offset_type'(2));
                  mode = LEX_IDLE;
               end else begin
                  add_token(bst_pkg::KIND_UNKNOWN, tok_start, bst_pkg::offset_type'(1));
                  from_idle(b);
               end
            end
            default: from_idle(b);
         endcase
         if (b == 8'd0) begin
            pos = '0;
            mode = LEX_IDLE;
         end else begin
            pos = sat_step(pos);
         end
         if (expected.size() > first) expected[expected.size()-1].last = 1'b1;
      endfunction

      function void check_token(logic [bst_pkg::RSP_DATA_BITS-1:0] data, logic last);
         token_record_type want;
         if (expected.size() == 0) begin
            $error("unexpected token: kind %0d start %0d length %0d",
                   data[4:0], data[20:5], data[36:21]);
            errors++;
            return;
         end
         want = expected.pop_front();
         if (data[4:0] !== want.kind) begin
            $error("token_kind: expected %0d, got %0d", want.kind, data[4:0]);
            errors++;
         end
         if (data[20:5] !== want.start) begin
            $error("token_start: expected %0d, got %0d", want.start, data[20:5]);
            errors++;
         end
         if (data[36:21] !== want.length) begin
            $error("token_length: expected %0d, got %0d", want.length, data[36:21]);
            errors++;
         end
         if (last !== want.last) begin
            $error("last_of_run: expected %0d, got %0d", want.last, last);
            errors++;
         end
      endfunction
   endclass

   logic                              clock;
   logic                              reset = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [7:0]                        req_tdata = 8'd0;
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   logic [bst_pkg::RSP_DATA_BITS-1:0] rsp_tdata;
   logic                              rsp_tlast;

   token_scoreboard_type sb;
   int          burst_left = 0;
   int          sent = 0;
   int          quiet_cycles = 0;
   rx_mode_type rx_mode = RX_ALWAYS;
   int          rx_count = 0;

   byte_stream_tokenizer uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // receiver backpressure: switches at random between ready patterns
   always @(posedge clock) begin
      if (rx_count == 0) begin
         rx_mode <= rx_mode_type'($urandom_range(0, 3));
         rx_count <= int'($urandom_range(16, 96));
      end else begin
         rx_count <= rx_count - 1;
      end
      case (rx_mode)
         RX_ALWAYS: rsp_tready <= 1'b1;
         RX_COIN: rsp_tready <= ($urandom_range(0, 1) == 1);
         RX_SPARSE: rsp_tready <= ($urandom_range(0, 3) == 0);
         default: rsp_tready <= rx_count[2];
      endcase
   end

   // inputs are noted before outputs are checked, within the same edge
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         if (req_tvalid && req_tready) sb.note_byte(req_tdata);
         if (rsp_tvalid && rsp_tready) sb.check_token(rsp_tdata, rsp_tlast);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT) begin
               $display("Some tests failed");
               $finish;
            end
         end
      end
   end

   task automatic send_byte(input logic [7:0] b);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata <= b;
      do @(posedge clock); while (!req_tready);
      sent++;
   endtask

   task automatic send_text(input logic [7:0] src[$]);
      foreach (src[i]) send_byte(src[i]);
   endtask

   // hold the sender until every outstanding token has come out
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   function automatic void add_str(ref logic [7:0] q[$], input string s);
      foreach (s[i]) q.push_back(s[i]);
   endfunction

   function automatic logic [7:0] rand_alpha();
      int r;
      r = $urandom_range(0, 51);
      return (r < 26) ? 8'("a" + r) : 8'("A" + r - 26);
   endfunction

   function automatic logic [7:0] rand_alnum();
      if ($urandom_range(0, 3) == 0) return 8'("0" + $urandom_range(0, 9));
      return rand_alpha();
   endfunction

   // any nonzero byte except the double quote
   function automatic logic [7:0] rand_string_byte();
      logic [7:0] r;
      r = 8'($urandom_range(1, 254));
      if (r >= 8'h22) r++;
      return r;
   endfunction

   function automatic void build_text(ref logic [7:0] q[$]);
      string words[10] = '{"print", "if", "else", "while", "prin", "iff",
                           "elsewhere", "While", "whil3", "printx"};
      string ops[14] = '{"==", "=", "<=", "<", "%", "+", "-", "*", "/", ";",
                         "(", ")", "{", "}"};
      logic [7:0] spaces[6] = '{8'd9, 8'd10, 8'd11, 8'd12, 8'd13, 8'd32};
      int count;
      int sel;
      count = $urandom_range(1, 12);
      repeat (count) begin
         sel = $urandom_range(0, 99);
         if (sel < 20) begin
            add_str(q, words[$urandom_range(0, 9)]);
         end else if (sel < 35) begin
            q.push_back(rand_alpha());
            repeat ($urandom_range(0, 7)) q.push_back(rand_alnum());
         end else if (sel < 47) begin
            repeat ($urandom_range(1, 6)) q.push_back(8'("0" + $urandom_range(0, 9)));
         end else if (sel < 60) begin
            q.push_back("\"");
            repeat ($urandom_range(0, 6)) q.push_back(rand_string_byte());
            q.push_back("\"");
         end else if (sel < 80) begin
            add_str(q, ops[$urandom_range(0, 13)]);
         end else if (sel < 90) begin
            repeat ($urandom_range(1, 3)) q.push_back(spaces[$urandom_range(0, 5)]);
         end else begin
            q.push_back(8'($urandom_range(1, 255)));
         end
         if ($urandom_range(0, 1) == 0) q.push_back(8'd32);
      end
      if ($urandom_range(0, 9) == 0) begin
         q.push_back("\"");
         repeat ($urandom_range(0, 4)) q.push_back(rand_string_byte());
      end
      q.push_back(8'd0);
   endfunction

   initial begin
      logic [7:0] src[$];
      sb = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // keywords, all operators, lone = and <, high bytes, unterminated string
      add_str(src, "if{else}while(print);");
      src.push_back(8'd0);
      add_str(src, "x=9<=22<\"s\"==%+-*/");
      src.push_back(8'hFF);
      src.push_back(8'h80);
      src.push_back(8'd9);
      add_str(src, "\"u");
      src.push_back(8'd0);
      send_text(src);
      wait_drained();

      while (sent < RANDOM_BYTES) begin
         src.delete();
         build_text(src);
         send_text(src);
         if ($urandom_range(0, 9) == 0) wait_drained();
      end
      wait_drained();

      repeat (20) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
